### sv/upd_pkg.sv
// shared types, character constants and hex digit helper for the url percent decoder
// no dependencies; the decoder, the queue and the top level refer to this package

package upd_pkg;

	localparam logic [7:0] PCT_CHAR     = 8'h25;
	localparam logic [7:0] ZERO_CHAR    = 8'h30;
	localparam logic [7:0] NINE_CHAR    = 8'h39;
	localparam logic [7:0] UPPER_A_CHAR = 8'h41;
	localparam logic [7:0] UPPER_F_CHAR = 8'h46;
	localparam logic [7:0] LOWER_A_CHAR = 8'h61;
	localparam logic [7:0] LOWER_F_CHAR = 8'h66;
	localparam logic [3:0] HEX_TEN      = 4'd10;

	localparam int MAX_RESULTS = 3;
	localparam int QUEUE_DEPTH = 8;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		PEND_NONE  = 2'd0,
		PEND_PCT   = 2'd1,
		PEND_DIGIT = 2'd2
	} pend_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_final;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_run_last;
		logic       out_string_end;
	} result_t;

	// results of one input word, slot 0 goes out first
	typedef struct packed {
		logic [NRES_W-1:0]            count;
		result_t [MAX_RESULTS-1:0]    slot;
	} burst_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_value(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b0;
		h.val = 4'd0;
		if (c >= ZERO_CHAR && c <= NINE_CHAR) begin
			h.ok  = 1'b1;
			h.val = 4'(c - ZERO_CHAR);
		end else if (c >= UPPER_A_CHAR && c <= UPPER_F_CHAR) begin
			h.ok  = 1'b1;
			h.val = 4'(c - UPPER_A_CHAR) + HEX_TEN;
		end else if (c >= LOWER_A_CHAR && c <= LOWER_F_CHAR) begin
			h.ok  = 1'b1;
			h.val = 4'(c - LOWER_A_CHAR) + HEX_TEN;
		end
		return h;
	endfunction

endpackage

### sv/upd_if.sv
// valid/ready channel interfaces for the url percent decoder
// depends on nothing; input carries encoded bytes, output carries decoded bytes

interface upd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_final;

	modport source(output valid, in_byte, in_final, input ready);
	modport sink(input valid, in_byte, in_final, output ready);
endinterface

interface upd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_run_last;
	logic       out_string_end;

	modport source(output valid, out_byte, out_run_last, out_string_end, input ready);
	modport sink(input valid, out_byte, out_run_last, out_string_end, output ready);
endinterface

### sv/upd_decoder.sv
// escape decoder: pending state plus the logic that turns one input word into up to
// three result words; depends on upd_pkg

module upd_decoder (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  upd_pkg::item_t  item,
	output upd_pkg::burst_t burst
);

	upd_pkg::pend_t pend_q;
	upd_pkg::pend_t pend_d;
	logic [7:0]     held_q;
	logic [7:0]     held_d;

	upd_pkg::hex_t hex_b;
	upd_pkg::hex_t hex_h;
	logic [1:0]    n_pre;
	logic          tail_en;
	logic [7:0]    tail_byte;
	logic          fresh_en;
	logic [upd_pkg::NRES_W-1:0] cnt;

	always_comb begin
		hex_b     = upd_pkg::hex_value(item.in_byte);
		hex_h     = upd_pkg::hex_value(held_q);
		// a lone '%' is held unless the string ends on it
		fresh_en  = !(item.in_byte == upd_pkg::PCT_CHAR && !item.in_final);
		n_pre     = 2'd0;
		tail_en   = fresh_en;
		tail_byte = item.in_byte;
		held_d    = held_q;
		pend_d    = fresh_en ? upd_pkg::PEND_NONE : upd_pkg::PEND_PCT;

		unique case (pend_q)
			upd_pkg::PEND_PCT: begin
				if (hex_b.ok) begin
					if (item.in_final) begin
						n_pre   = 2'd1;
						tail_en = 1'b1;
						pend_d  = upd_pkg::PEND_NONE;
					end else begin
						tail_en = 1'b0;
						held_d  = item.in_byte;
						pend_d  = upd_pkg::PEND_DIGIT;
					end
				end else begin
					n_pre = 2'd1;
				end
			end
			upd_pkg::PEND_DIGIT: begin
				if (hex_h.ok && hex_b.ok &&
				    !(held_q == upd_pkg::ZERO_CHAR && item.in_byte == upd_pkg::ZERO_CHAR)) begin
					tail_en   = 1'b1;
					tail_byte = {hex_h.val, hex_b.val};
					pend_d    = upd_pkg::PEND_NONE;
				end else begin
					n_pre = 2'd2;
				end
			end
			default: begin
			end
		endcase

		if (item.in_final)
			pend_d = upd_pkg::PEND_NONE;

		cnt = upd_pkg::NRES_W'(n_pre) + upd_pkg::NRES_W'(tail_en);

		burst.count = cnt;
		burst.slot[0].out_byte = (n_pre != 2'd0) ? upd_pkg::PCT_CHAR : tail_byte;
		burst.slot[1].out_byte = (n_pre == 2'd2) ? held_q : tail_byte;
		burst.slot[2].out_byte = tail_byte;
		for (int k = 0; k < upd_pkg::MAX_RESULTS; k++) begin
			burst.slot[k].out_run_last   = (cnt == upd_pkg::NRES_W'(k + 1));
			burst.slot[k].out_string_end = (cnt == upd_pkg::NRES_W'(k + 1)) && item.in_final;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= upd_pkg::PEND_NONE;
			held_q <= 8'd0;
		end else if (advance) begin
			pend_q <= pend_d;
			held_q <= held_d;
		end
	end

endmodule

### sv/upd_out_queue.sv
// result queue: takes up to three words per cycle, gives one word per cycle while dec is ready
// depends on upd_pkg and upd_out_if

module upd_out_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  upd_pkg::burst_t   burst,
	output logic              room,
	upd_out_if.source         dec
);

	upd_pkg::result_t             entry_q [upd_pkg::QUEUE_DEPTH];
	logic [upd_pkg::PTR_W-1:0]    wr_ptr_q;
	logic [upd_pkg::PTR_W-1:0]    rd_ptr_q;
	logic [upd_pkg::CNT_W-1:0]    count_q;
	logic                         pop;
	logic [upd_pkg::CNT_W-1:0]    push_n;

	assign pop    = dec.valid && dec.ready;
	assign push_n = push ? upd_pkg::CNT_W'(burst.count) : '0;

	// room for a full burst once this cycle's pop is counted
	assign room = (count_q <= upd_pkg::CNT_W'(upd_pkg::QUEUE_DEPTH - upd_pkg::MAX_RESULTS)) ||
	              (pop && count_q <= upd_pkg::CNT_W'(upd_pkg::QUEUE_DEPTH - upd_pkg::MAX_RESULTS + 1));

	assign dec.valid          = (count_q != '0);
	assign dec.out_byte       = entry_q[rd_ptr_q].out_byte;
	assign dec.out_run_last   = entry_q[rd_ptr_q].out_run_last;
	assign dec.out_string_end = entry_q[rd_ptr_q].out_string_end;

	always_ff @(posedge clk) begin
		if (push) begin
			for (int k = 0; k < upd_pkg::MAX_RESULTS; k++) begin
				if (upd_pkg::NRES_W'(k) < burst.count)
					entry_q[wr_ptr_q + upd_pkg::PTR_W'(k)] <= burst.slot[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + upd_pkg::PTR_W'(push_n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + upd_pkg::PTR_W'(1);
			count_q <= count_q + push_n - upd_pkg::CNT_W'(pop);
		end
	end

endmodule

### sv/url_percent_decoder_core.sv
// top level of the url percent decoder: input register, escape decoder, result queue
// depends on upd_pkg, upd_if, upd_decoder and upd_out_queue

// Decodes a URL percent-encoded byte string, one encoded byte per cycle while the
// queue has room. A word accepted on enc is registered, decoded once the queue has
// room for its burst, and its zero to three result words enter an eight-word queue
// that feeds dec one word per cycle while dec is ready. "%00" stays literal, broken
// escapes are passed through unchanged, and a pending '%' or digit is flushed on the
// word marked in_final. A result reaches dec through the input register and the queue.
// Input stalls only while the queue lacks room for a full burst of three words, which
// is set by the downstream rate on dec.

module url_percent_decoder_core (
	input  logic      clk,
	input  logic      arst_n,
	upd_in_if.sink    enc,
	upd_out_if.source dec
);

	logic            valid_s1;
	upd_pkg::item_t  item_s1;
	logic            advance;
	logic            room;
	upd_pkg::burst_t burst;

	assign advance   = valid_s1 && room;
	assign enc.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (enc.ready) begin
			valid_s1 <= enc.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (enc.ready && enc.valid) begin
			item_s1.in_byte  <= enc.in_byte;
			item_s1.in_final <= enc.in_final;
		end
	end

	upd_decoder u_decoder (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.item   (item_s1),
		.burst  (burst)
	);

	upd_out_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (advance),
		.burst  (burst),
		.room   (room),
		.dec    (dec)
	);

endmodule
